>>> src/prot2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// prot2d_pkg
// Shared constants for the 2D point rotator: working precision, the CORDIC
// gain compensation factor and the arctangent table in units of a turn.
// ============================================================================
package prot2d_pkg;

    // Extra fraction bits carried through the rotation datapath.
    localparam int GUARD_BITS = 16;

    // Width of the residual angle accumulator, where 2^32 is one full turn.
    localparam int ZW = 32;

    // CORDIC gain compensation K = 0.60725..., scaled by 2^32.
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    // Largest number of micro-rotations the table supports.
    localparam int MAX_STEPS = 32;

    // atan(2^-i) / (2*pi) * 2^32, rounded to nearest.
    localparam logic [31:0] ATAN_TURN [MAX_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage : prot2d_pkg
`default_nettype wire

>>> src/prot2d_prescale.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// prot2d_prescale
// Two-stage front end: multiplies the coordinates by the CORDIC gain
// compensation, rounds into the working format and applies the exact
// quarter-turn pre-rotation selected by the top two angle bits.
// ============================================================================
module prot2d_prescale #(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int WORK_WIDTH  = 34
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                valid_in,
    input  wire logic signed [DATA_WIDTH-1:0]        x_in,
    input  wire logic signed [DATA_WIDTH-1:0]        y_in,
    input  wire logic        [ANGLE_WIDTH-1:0]       angle_in,
    output logic                                     valid_out,
    output logic signed [WORK_WIDTH-1:0]             x_out,
    output logic signed [WORK_WIDTH-1:0]             y_out,
    output logic signed [prot2d_pkg::ZW-1:0]         z_out
);
    import prot2d_pkg::*;

    // Product of a DATA_WIDTH signed value and a 33-bit non-negative gain.
    localparam int PW = DATA_WIDTH + 33;
    localparam int PRE_SHIFT = 32 - GUARD_BITS;
    localparam logic signed [32:0] GAIN_S = {1'b0, GAIN_Q32};
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (PRE_SHIFT - 1);

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    logic                   valid1_reg;
    logic signed [PW-1:0]   prod_x_reg, prod_x_next;
    logic signed [PW-1:0]   prod_y_reg, prod_y_next;
    quad_t                  quad_reg, quad_next;
    logic signed [ZW-1:0]   z1_reg, z1_next;

    logic                   valid2_reg;
    logic signed [WORK_WIDTH-1:0] x2_reg, x2_next;
    logic signed [WORK_WIDTH-1:0] y2_reg, y2_next;
    logic signed [ZW-1:0]   z2_reg;

    logic signed [PW-1:0]   sum_x, sum_y;
    logic signed [WORK_WIDTH-1:0] sx, sy;

    // Stage 1: gain multiply and split of the angle into quadrant and residual.
    always_comb
    begin
        prod_x_next = PW'(x_in) * PW'(GAIN_S);
        prod_y_next = PW'(y_in) * PW'(GAIN_S);
        quad_next   = quad_t'(angle_in[ANGLE_WIDTH-1 -: 2]);
        z1_next     = ZW'(angle_in[ANGLE_WIDTH-3:0]) << (ZW - ANGLE_WIDTH);
    end

    // Stage 2: round into the working format, then the quarter-turn rotation.
    always_comb
    begin
        sum_x = prod_x_reg + ROUND_HALF;
        sum_y = prod_y_reg + ROUND_HALF;
        sx    = WORK_WIDTH'(sum_x >>> PRE_SHIFT);
        sy    = WORK_WIDTH'(sum_y >>> PRE_SHIFT);
        unique case (quad_reg)
            QUAD_0:
            begin
                x2_next = sx;
                y2_next = sy;
            end
            QUAD_90:
            begin
                x2_next = -sy;
                y2_next = sx;
            end
            QUAD_180:
            begin
                x2_next = -sx;
                y2_next = -sy;
            end
            QUAD_270:
            begin
                x2_next = sy;
                y2_next = -sx;
            end
            default:
            begin
                x2_next = sx;
                y2_next = sy;
            end
        endcase
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid_in;
            valid2_reg <= valid1_reg;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        quad_reg   <= quad_next;
        z1_reg     <= z1_next;
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        z2_reg     <= z1_reg;
    end

    assign valid_out = valid2_reg;
    assign x_out     = x2_reg;
    assign y_out     = y2_reg;
    assign z_out     = z2_reg;

endmodule : prot2d_prescale
`default_nettype wire

>>> src/prot2d_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// prot2d_cordic_stage
// One registered CORDIC micro-rotation. The sign of the residual angle picks
// the rotation direction; the shift distance and arctangent are fixed by STEP.
// ============================================================================
module prot2d_cordic_stage #(
    parameter int WORK_WIDTH = 34,
    parameter int STEP       = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              valid_in,
    input  wire logic signed [WORK_WIDTH-1:0]      x_in,
    input  wire logic signed [WORK_WIDTH-1:0]      y_in,
    input  wire logic signed [prot2d_pkg::ZW-1:0]  z_in,
    output logic                                   valid_out,
    output logic signed [WORK_WIDTH-1:0]           x_out,
    output logic signed [WORK_WIDTH-1:0]           y_out,
    output logic signed [prot2d_pkg::ZW-1:0]       z_out
);
    import prot2d_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_STEP = ATAN_TURN[STEP];

    logic                         valid_reg;
    logic signed [WORK_WIDTH-1:0] x_reg, x_next;
    logic signed [WORK_WIDTH-1:0] y_reg, y_next;
    logic signed [ZW-1:0]         z_reg, z_next;
    logic signed [WORK_WIDTH-1:0] dx, dy;

    // Micro-rotation: rotate toward a residual angle of zero.
    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!z_in[ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_STEP;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_STEP;
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule : prot2d_cordic_stage
`default_nettype wire

>>> src/prot2d_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// prot2d_finish
// Output stage: drops the guard bits with round-half-up, saturates each
// coordinate to the output range and registers the result word and its flag.
// ============================================================================
module prot2d_finish #(
    parameter int DATA_WIDTH = 16,
    parameter int WORK_WIDTH = 34
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              valid_in,
    input  wire logic signed [WORK_WIDTH-1:0]      x_in,
    input  wire logic signed [WORK_WIDTH-1:0]      y_in,
    output logic                                   done,
    output logic signed [DATA_WIDTH-1:0]           out_x,
    output logic signed [DATA_WIDTH-1:0]           out_y,
    output logic                                   clipped
);
    import prot2d_pkg::*;

    localparam int RW = WORK_WIDTH - GUARD_BITS;
    localparam logic signed [WORK_WIDTH-1:0] ROUND_HALF =
        WORK_WIDTH'(1) << (GUARD_BITS - 1);
    localparam logic signed [RW-1:0] R_MAX =
        {{(RW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [RW-1:0] R_MIN =
        {{(RW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                         done_reg;
    logic signed [DATA_WIDTH-1:0] out_x_reg, out_x_next;
    logic signed [DATA_WIDTH-1:0] out_y_reg, out_y_next;
    logic                         clipped_reg, clipped_next;
    logic signed [RW-1:0]         rx, ry;
    logic                         sat_x, sat_y;

    // Round away the guard bits, then clamp to the output range.
    always_comb
    begin
        rx    = RW'((x_in + ROUND_HALF) >>> GUARD_BITS);
        ry    = RW'((y_in + ROUND_HALF) >>> GUARD_BITS);
        sat_x = (rx > R_MAX) || (rx < R_MIN);
        sat_y = (ry > R_MAX) || (ry < R_MIN);
        if (rx > R_MAX)
        begin
            out_x_next = OUT_MAX;
        end
        else if (rx < R_MIN)
        begin
            out_x_next = OUT_MIN;
        end
        else
        begin
            out_x_next = DATA_WIDTH'(rx);
        end
        if (ry > R_MAX)
        begin
            out_y_next = OUT_MAX;
        end
        else if (ry < R_MIN)
        begin
            out_y_next = OUT_MIN;
        end
        else
        begin
            out_y_next = DATA_WIDTH'(ry);
        end
        clipped_next = valid_in & (sat_x | sat_y);
    end

    // Control: the result strobe and its flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            clipped_reg <= 1'b0;
        end
        else
        begin
            done_reg    <= valid_in;
            clipped_reg <= clipped_next;
        end
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
    end

    assign done    = done_reg;
    assign out_x   = out_x_reg;
    assign out_y   = out_y_reg;
    assign clipped = clipped_reg;

    // The flag is only ever raised together with the strobe.
    a_clip_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        clipped |-> done)
        else $error("clipped raised without done");

    // A clipped result has at least one coordinate at a range limit.
    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        clipped |-> (out_x == OUT_MAX || out_x == OUT_MIN ||
                     out_y == OUT_MAX || out_y == OUT_MIN))
        else $error("clipped set but no coordinate is at a range limit");

    // An unsaturated coordinate passes the rounded value through unchanged.
    a_no_clip_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_in && !sat_x) |=> (out_x == $past(DATA_WIDTH'(rx))))
        else $error("unsaturated x did not pass through");

endmodule : prot2d_finish
`default_nettype wire

>>> src/point_rotator_2d.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// point_rotator_2d
// Rotates a 2D point anticlockwise about the origin with a pipelined CORDIC.
// ============================================================================
// Usage:
//   A word (in_x, in_y, turn_angle) is taken at a rising edge where start is
//   high and busy is low. busy stays low: the pipeline takes a new word in
//   every cycle, so the sustained rate is one point per clock.
//   Coordinates are signed Q1.14 at the default width; turn_angle is a binary
//   fraction of a full turn (2^ANGLE_WIDTH is one turn).
//   The result word (out_x, out_y, clipped) is on the outputs for exactly one
//   cycle, marked by done. It passes one register stage for the gain
//   multiply, one for rounding and the quarter-turn pre-rotation, one per
//   CORDIC micro-rotation and one for rounding and saturation.
//   clipped is high when either coordinate saturated.
//   Reset clears every valid bit, so no result word appears from words in
//   flight at reset. The receiver cannot stall the block: every result word
//   is presented once and never held.
// ============================================================================
module point_rotator_2d #(
    parameter int DATA_WIDTH     = 16,
    parameter int ANGLE_WIDTH    = 16,
    parameter int ROTATION_STEPS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [DATA_WIDTH-1:0]  in_x,
    input  wire logic signed [DATA_WIDTH-1:0]  in_y,
    input  wire logic        [ANGLE_WIDTH-1:0] turn_angle,
    output logic                               done,
    output logic signed [DATA_WIDTH-1:0]       out_x,
    output logic signed [DATA_WIDTH-1:0]       out_y,
    output logic                               clipped
);
    import prot2d_pkg::*;

    // Working width: the gain-compensated value with guard bits, plus
    // headroom for the quarter-turn and the CORDIC gain.
    localparam int WW      = DATA_WIDTH + GUARD_BITS + 2;
    localparam int LATENCY = ROTATION_STEPS + 3;

    logic                  stage_valid [ROTATION_STEPS+1];
    logic signed [WW-1:0]  stage_x     [ROTATION_STEPS+1];
    logic signed [WW-1:0]  stage_y     [ROTATION_STEPS+1];
    logic signed [ZW-1:0]  stage_z     [ROTATION_STEPS+1];

    // The pipeline never stalls, so a word is taken whenever start is high.
    assign busy = 1'b0;

    // Gain compensation and quarter-turn pre-rotation.
    prot2d_prescale #(
        .DATA_WIDTH  (DATA_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .WORK_WIDTH  (WW)
    ) u_prescale (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start & ~busy),
        .x_in      (in_x),
        .y_in      (in_y),
        .angle_in  (turn_angle),
        .valid_out (stage_valid[0]),
        .x_out     (stage_x[0]),
        .y_out     (stage_y[0]),
        .z_out     (stage_z[0])
    );

    // One registered micro-rotation per step.
    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_step
        prot2d_cordic_stage #(
            .WORK_WIDTH (WW),
            .STEP       (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[i]),
            .x_in      (stage_x[i]),
            .y_in      (stage_y[i]),
            .z_in      (stage_z[i]),
            .valid_out (stage_valid[i+1]),
            .x_out     (stage_x[i+1]),
            .y_out     (stage_y[i+1]),
            .z_out     (stage_z[i+1])
        );
    end

    // Rounding, saturation and the result register.
    prot2d_finish #(
        .DATA_WIDTH (DATA_WIDTH),
        .WORK_WIDTH (WW)
    ) u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (stage_valid[ROTATION_STEPS]),
        .x_in     (stage_x[ROTATION_STEPS]),
        .y_in     (stage_y[ROTATION_STEPS]),
        .done     (done),
        .out_x    (out_x),
        .out_y    (out_y),
        .clipped  (clipped)
    );

    // Every accepted word yields exactly one result a fixed time later.
    a_one_result_per_word: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, LATENCY) |-> (done == $past(start, LATENCY)))
        else $error("result strobe does not match accepted words");

endmodule : point_rotator_2d
`default_nettype wire

>>> tb/point_rotator_2d_test.sv
`timescale 1ns / 1ps
// ============================================================================
// point_rotator_2d_test
// Self-checking testbench for the 2D point rotator. A directed set covers the
// coordinate extremes, every quadrant and saturating rotations, then random
// points follow with random gaps between words. Every accepted word is run
// through a bit-exact CORDIC predictor, and each result word is compared
// field by field with the oldest prediction.
// ============================================================================
module point_rotator_2d_test;

    localparam int DW         = 16;
    localparam int AW         = 16;
    localparam int STEPS      = 16;
    localparam int GUARD      = 16;
    localparam int RAND_WORDS = 530;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN      = 40;
    localparam int MAX_SHOWN  = 10;

    // Gain compensation K = 0.60725... scaled by 2^32.
    localparam longint GAIN_K = 64'sd2608131496;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
    localparam longint ATAN_STEP [STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef struct {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic [AW-1:0]        angle;
        int unsigned          gap;
    } point_word_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic                 clipped;
    } rotated_word_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic signed [DW-1:0] in_x       = '0;
    logic signed [DW-1:0] in_y       = '0;
    logic [AW-1:0]        turn_angle = '0;
    logic                 busy;
    logic                 done;
    logic signed [DW-1:0] out_x;
    logic signed [DW-1:0] out_y;
    logic                 clipped;

    point_word_t   pending_points[$];
    rotated_word_t rotated_points[$];
    rotated_word_t predicted;
    int unsigned   words_queued   = 0;
    int unsigned   words_accepted = 0;
    int unsigned   gap_count      = 0;
    int unsigned   idle_cycles    = 0;
    int unsigned   error_count    = 0;
    logic          word_taken     = 1'b0;

    point_rotator_2d #(
        .DATA_WIDTH    (DW),
        .ANGLE_WIDTH   (AW),
        .ROTATION_STEPS(STEPS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_x      (in_x),
        .in_y      (in_y),
        .turn_angle(turn_angle),
        .done      (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .clipped   (clipped)
    );

    always #5 clk = ~clk;

    // Drop the guard bits with round half up, then clamp to the output range.
    function automatic logic signed [DW-1:0] round_and_clamp(input longint v,
                                                             inout bit sat);
        longint r;
        r = (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
        if (r > (64'sd1 <<< (DW - 1)) - 1) begin
            r = (64'sd1 <<< (DW - 1)) - 1;
            sat = 1'b1;
        end
        if (r < -(64'sd1 <<< (DW - 1))) begin
            r = -(64'sd1 <<< (DW - 1));
            sat = 1'b1;
        end
        return r[DW-1:0];
    endfunction

    // Bit-exact rotation: gain compensation, quarter-turn pre-rotation, then
    // the CORDIC micro-rotations over the residual angle.
    function automatic rotated_word_t rotate_point(input logic signed [DW-1:0] px,
                                                   input logic signed [DW-1:0] py,
                                                   input logic [AW-1:0] ang);
        longint        x;
        longint        y;
        longint        z;
        longint        t;
        longint        dx;
        longint        dy;
        bit            sat;
        rotated_word_t r;
        x = px;
        y = py;
        x = (x * GAIN_K + (64'sd1 <<< (31 - GUARD))) >>> (32 - GUARD);
        y = (y * GAIN_K + (64'sd1 <<< (31 - GUARD))) >>> (32 - GUARD);
        z = longint'({1'b0, ang[AW-3:0]}) <<< (32 - AW);
        case (ang[AW-1:AW-2])
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        sat = 1'b0;
        r.x = round_and_clamp(x, sat);
        r.y = round_and_clamp(y, sat);
        r.clipped = sat;
        return r;
    endfunction

    // Queue one point; every fourth stretch of 40 words runs back to back.
    task automatic add_point(input logic signed [DW-1:0] x,
                             input logic signed [DW-1:0] y,
                             input logic [AW-1:0] ang);
        point_word_t p;
        p.x = x;
        p.y = y;
        p.angle = ang;
        p.gap = ((words_queued / 40) % 4 == 3) ? 0 : $urandom_range(0, 9);
        pending_points.push_back(p);
        words_queued++;
    endtask

    // Driver: presents the next word after its gap and holds it until taken.
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (start && !word_taken) begin
            start <= 1'b1;
        end else if (pending_points.size() == 0) begin
            start <= 1'b0;
        end else if (gap_count < pending_points[0].gap) begin
            start     <= 1'b0;
            gap_count <= gap_count + 1;
        end else begin
            in_x       <= pending_points[0].x;
            in_y       <= pending_points[0].y;
            turn_angle <= pending_points[0].angle;
            start      <= 1'b1;
            gap_count  <= 0;
            void'(pending_points.pop_front());
        end
    end

    // Monitor: checks result words and predicts every accepted word.
    always @(posedge clk) begin
        if (rst_n) begin
            if (done === 1'b1) begin
                if (rotated_points.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("unexpected result word: x=%0d y=%0d clipped=%b",
                                 out_x, out_y, clipped);
                end else begin
                    predicted = rotated_points.pop_front();
                    if (out_x !== predicted.x || out_y !== predicted.y ||
                        clipped !== predicted.clipped) begin
                        error_count++;
                        if (error_count <= MAX_SHOWN)
                            $display("mismatch: want x=%0d y=%0d clipped=%b, got x=%0d y=%0d clipped=%b",
                                     predicted.x, predicted.y, predicted.clipped,
                                     out_x, out_y, clipped);
                    end
                end
            end
            if (start && !busy) begin
                rotated_points.push_back(rotate_point(in_x, in_y, turn_angle));
                words_accepted++;
            end
        end
        word_taken <= rst_n && start && !busy;
    end

    // Watchdog on cycles in which no word moves in either direction.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done === 1'b1)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [AW-1:0]        ang;
        logic signed [DW-1:0] rx;
        logic signed [DW-1:0] ry;

        // Directed words: extremes, each quadrant boundary and saturation.
        add_point(16'sd16384, 16'sd0, 16'h0000);
        add_point(16'sd16384, 16'sd0, 16'h4000);
        add_point(16'sd16384, 16'sd0, 16'h8000);
        add_point(16'sd16384, 16'sd0, 16'hC000);
        add_point(16'sd16384, 16'sd0, 16'h2000);
        add_point(16'sd0, 16'sd16384, 16'hFFFF);
        add_point(-16'sd32768, 16'sd0, 16'h4000);
        add_point(-16'sd32768, -16'sd32768, 16'h2000);
        add_point(16'sd32767, 16'sd32767, 16'h2000);
        add_point(16'sd32767, 16'sd32767, 16'h0000);
        add_point(-16'sd32768, -16'sd32768, 16'h0000);
        add_point(-16'sd32768, 16'sd32767, 16'h8000);
        add_point(16'sd32767, -16'sd32768, 16'h6000);
        add_point(16'sd0, 16'sd0, 16'h1234);
        add_point(16'sd1, -16'sd1, 16'hE000);
        add_point(-16'sd1, 16'sd1, 16'h3FFF);
        add_point(16'sd32767, 16'sd0, 16'h0001);
        add_point(16'sd0, -16'sd32768, 16'hBFFF);
        add_point(16'sd12345, -16'sd23456, 16'h5555);
        add_point(-16'sd20000, 16'sd30000, 16'hAAAA);

        // Random words in four flavors: full range, small, near the edges of
        // the range, and angles next to a quarter-turn boundary.
        for (int n = 0; n < RAND_WORDS; n++) begin
            rx  = DW'($urandom);
            ry  = DW'($urandom);
            ang = AW'($urandom);
            case ($urandom_range(0, 3))
                1: begin
                    rx = DW'($urandom_range(0, 1023) - 512);
                    ry = DW'($urandom_range(0, 1023) - 512);
                end
                2: begin
                    rx = DW'($urandom_range(0, 1) ? 16'sh7FFF - $urandom_range(0, 2)
                                                  : 16'sh8000 + $urandom_range(0, 2));
                    ry = DW'($urandom_range(0, 1) ? 16'sh7FFF - $urandom_range(0, 2)
                                                  : 16'sh8000 + $urandom_range(0, 2));
                end
                3: ang = AW'(($urandom_range(0, 3) << (AW - 2)) + $urandom_range(0, 4) - 2);
                default: ;
            endcase
            add_point(rx, ry, ang);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken and every result to come back.
        do
            @(negedge clk);
        while (words_accepted != words_queued || rotated_points.size() != 0);

        // Let the pipeline drain so a stray late word would be caught.
        repeat (DRAIN) @(negedge clk);

        if (error_count == 0 && rotated_points.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
